// File: design/qs_pkg.sv
// Package with the shared types of the quicksort sorter: commands, status and states.
`default_nettype none

package qs_pkg;

  // Commands from the controller to the datapath, one per cycle.
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_INIT,
    CMD_POP,
    CMD_RANGE_LD,
    CMD_PV_LD,
    CMD_RD_RGT,
    CMD_R_STEP,
    CMD_RD_LFT,
    CMD_L_STEP,
    CMD_FIN,
    CMD_PUSH_L,
    CMD_PUSH_R,
    CMD_OUT_RD,
    CMD_OUT_LD,
    CMD_OUT_TAKE
  } cmd_e;

  // Controller states.
  typedef enum logic [3:0] {
    ST_LOAD,
    ST_INIT,
    ST_POP_CHK,
    ST_POP_WAIT,
    ST_PIV_WAIT,
    ST_R_CHK,
    ST_R_CMP,
    ST_L_CHK,
    ST_L_CMP,
    ST_FIN,
    ST_PUSH_L,
    ST_PUSH_R,
    ST_OUT_RD,
    ST_OUT_LD,
    ST_OUT_HOLD
  } state_e;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic sp_zero;
    logic range_bad;
    logic piv_eq_rgt;
    logic piv_eq_lft;
    logic r_swap;
    logic l_swap;
    logic out_last;
  } status_t;

endpackage

`default_nettype wire

// File: design/qs_datapath.sv
// Datapath of the quicksort sorter: element store, range stack, scan indices and output beat.
`default_nettype none

module qs_datapath #(
  parameter int MAX_ELEMENTS = 64,
  parameter int DATA_WIDTH   = 32
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  qs_pkg::cmd_e                  cmd_i,
  input  wire signed [DATA_WIDTH-1:0]   value_i,
  output qs_pkg::status_t               status_o,
  output logic signed [DATA_WIDTH-1:0]  sorted_value_o,
  output logic                          last_out_o,
  output logic                          overflow_o
);
  import qs_pkg::*;

  localparam int IDXW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CNTW = $clog2(MAX_ELEMENTS + 1);
  localparam logic [CNTW-1:0] MaxCnt = CNTW'(MAX_ELEMENTS);

  // Storage.
  logic signed [DATA_WIDTH-1:0] store_mem [MAX_ELEMENTS];
  logic [2*IDXW-1:0]            stack_mem [MAX_ELEMENTS];
  logic signed [DATA_WIDTH-1:0] rdata_q;
  logic [2*IDXW-1:0]            srdata_q;

  logic [CNTW-1:0] count_q, count_d, sp_q, sp_d, k_q, k_d;
  logic            ovf_q, ovf_d;
  logic [IDXW-1:0] low_q, low_d, high_q, high_d;
  logic [IDXW-1:0] piv_q, piv_d, lft_q, lft_d, rgt_q, rgt_d;
  logic signed [DATA_WIDTH-1:0] pv_q, pv_d;
  logic            out_last_q, out_last_d;
  logic signed [DATA_WIDTH-1:0] outv_q, outv_d;
  logic            out_ovf_q, out_ovf_d;

  logic [IDXW-1:0] raddr, waddr, s_low, s_high;
  logic            rd_en, wr_en, push_en, pop_en;
  logic signed [DATA_WIDTH-1:0] wdata;
  logic [2*IDXW-1:0] push_data;
  logic [IDXW:0]   low_p1, piv_p1;
  logic            sp_room;

  assign s_low   = srdata_q[2*IDXW-1:IDXW];
  assign s_high  = srdata_q[IDXW-1:0];
  assign low_p1  = {1'b0, low_q} + 1'b1;
  assign piv_p1  = {1'b0, piv_q} + 1'b1;
  assign sp_room = sp_q < MaxCnt;

  // Status towards the controller.
  always_comb begin
    status_o.sp_zero    = (sp_q == '0);
    status_o.range_bad  = (s_low >= s_high) || (CNTW'(s_high) >= count_q);
    status_o.piv_eq_rgt = (piv_q == rgt_q);
    status_o.piv_eq_lft = (piv_q == lft_q);
    status_o.r_swap     = rdata_q < pv_q;
    status_o.l_swap     = pv_q < rdata_q;
    status_o.out_last   = out_last_q;
  end

  // Command decode: next values of the index registers and memory controls.
  always_comb begin
    count_d = count_q; sp_d = sp_q; k_d = k_q; ovf_d = ovf_q;
    low_d = low_q; high_d = high_q; piv_d = piv_q; lft_d = lft_q; rgt_d = rgt_q;
    pv_d = pv_q; out_last_d = out_last_q; outv_d = outv_q; out_ovf_d = out_ovf_q;
    raddr = k_q[IDXW-1:0]; rd_en = 1'b0;
    waddr = piv_q; wdata = rdata_q; wr_en = 1'b0;
    push_en = 1'b0; push_data = {low_q, high_q}; pop_en = 1'b0;
    unique case (cmd_i)
      CMD_LOAD: begin
        if (count_q < MaxCnt) begin
          waddr   = count_q[IDXW-1:0];
          wdata   = value_i;
          wr_en   = 1'b1;
          count_d = count_q + 1'b1;
        end else begin
          ovf_d = 1'b1;
        end
      end
      CMD_INIT: begin
        k_d  = '0;
        sp_d = '0;
        if (count_q >= CNTW'(2)) begin
          push_en   = 1'b1;
          push_data = {IDXW'(0), IDXW'(count_q - 1'b1)};
          sp_d      = CNTW'(1);
        end
      end
      CMD_POP: begin
        pop_en = 1'b1;
        sp_d   = sp_q - 1'b1;
      end
      CMD_RANGE_LD: begin
        low_d = s_low; high_d = s_high;
        piv_d = s_low; lft_d = s_low; rgt_d = s_high;
        raddr = s_low; rd_en = 1'b1;
      end
      CMD_PV_LD: pv_d = rdata_q;
      CMD_RD_RGT: begin
        raddr = rgt_q; rd_en = 1'b1;
      end
      CMD_R_STEP: begin
        if (rdata_q < pv_q) begin
          wr_en = 1'b1;
          piv_d = rgt_q;
        end else begin
          rgt_d = rgt_q - 1'b1;
        end
      end
      CMD_RD_LFT: begin
        raddr = lft_q; rd_en = 1'b1;
      end
      CMD_L_STEP: begin
        if (pv_q < rdata_q) begin
          wr_en = 1'b1;
          piv_d = lft_q;
        end else begin
          lft_d = lft_q + 1'b1;
        end
      end
      CMD_FIN: begin
        wdata = pv_q;
        wr_en = 1'b1;
      end
      CMD_PUSH_L: begin
        if (({1'b0, piv_q} > low_p1) && sp_room) begin
          push_en   = 1'b1;
          push_data = {low_q, piv_q - 1'b1};
          sp_d      = sp_q + 1'b1;
        end
      end
      CMD_PUSH_R: begin
        if ((piv_p1 < {1'b0, high_q}) && sp_room) begin
          push_en   = 1'b1;
          push_data = {piv_p1[IDXW-1:0], high_q};
          sp_d      = sp_q + 1'b1;
        end
      end
      CMD_OUT_RD: begin
        raddr = k_q[IDXW-1:0]; rd_en = 1'b1;
      end
      CMD_OUT_LD: begin
        outv_d     = rdata_q;
        out_last_d = (k_q + 1'b1) == count_q;
        out_ovf_d  = ovf_q;
      end
      CMD_OUT_TAKE: begin
        k_d = k_q + 1'b1;
        if (out_last_q) begin
          count_d = '0; ovf_d = 1'b0; k_d = '0; sp_d = '0;
        end
      end
      default: ;
    endcase
  end

  // Element store: one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) store_mem[waddr] <= wdata;
    if (rd_en) rdata_q <= store_mem[raddr];
  end

  // Range stack: push and pop never fall in the same cycle.
  always_ff @(posedge clk_i) begin
    if (push_en) stack_mem[sp_d[IDXW-1:0] - 1'b1] <= push_data;
    if (pop_en)  srdata_q <= stack_mem[sp_d[IDXW-1:0]];
  end

  // Control and index registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0; sp_q <= '0; k_q <= '0; ovf_q <= 1'b0; out_last_q <= 1'b0;
      low_q <= '0; high_q <= '0; piv_q <= '0; lft_q <= '0; rgt_q <= '0;
    end else begin
      count_q <= count_d; sp_q <= sp_d; k_q <= k_d; ovf_q <= ovf_d;
      out_last_q <= out_last_d;
      low_q <= low_d; high_q <= high_d; piv_q <= piv_d; lft_q <= lft_d; rgt_q <= rgt_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    pv_q <= pv_d; outv_q <= outv_d; out_ovf_q <= out_ovf_d;
  end

  assign sorted_value_o = outv_q;
  assign last_out_o     = out_last_q;
  assign overflow_o     = out_ovf_q;

  // Checks on the index bookkeeping.
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MaxCnt) else $error("element count beyond capacity");
  a_sp_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= MaxCnt) else $error("range stack beyond capacity");
  a_scan_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lft_q <= piv_q) && (piv_q <= rgt_q)) else $error("pivot outside scan window");
  a_take_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i == CMD_OUT_TAKE |-> k_q < count_q) else $error("beat beyond stored set");

endmodule

`default_nettype wire

// File: design/qs_ctrl.sv
// Controller of the quicksort sorter: sequences loading, partitioning and output.
`default_nettype none

module qs_ctrl (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  input  wire              is_last_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  wire              out_ready_i,
  input  qs_pkg::status_t  status_i,
  output qs_pkg::cmd_e     cmd_o
);
  import qs_pkg::*;

  state_e state_q, state_d;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD:     if (in_valid_i && is_last_i) state_d = ST_INIT;
      ST_INIT:     state_d = ST_POP_CHK;
      ST_POP_CHK:  state_d = status_i.sp_zero ? ST_OUT_RD : ST_POP_WAIT;
      ST_POP_WAIT: state_d = status_i.range_bad ? ST_POP_CHK : ST_PIV_WAIT;
      ST_PIV_WAIT: state_d = ST_R_CHK;
      ST_R_CHK:    state_d = status_i.piv_eq_rgt ? ST_FIN : ST_R_CMP;
      ST_R_CMP:    state_d = status_i.r_swap ? ST_L_CHK : ST_R_CHK;
      ST_L_CHK:    state_d = status_i.piv_eq_lft ? ST_FIN : ST_L_CMP;
      ST_L_CMP:    state_d = status_i.l_swap ? ST_R_CHK : ST_L_CHK;
      ST_FIN:      state_d = ST_PUSH_L;
      ST_PUSH_L:   state_d = ST_PUSH_R;
      ST_PUSH_R:   state_d = ST_POP_CHK;
      ST_OUT_RD:   state_d = ST_OUT_LD;
      ST_OUT_LD:   state_d = ST_OUT_HOLD;
      ST_OUT_HOLD: if (out_ready_i) state_d = status_i.out_last ? ST_LOAD : ST_OUT_RD;
      default:     state_d = ST_LOAD;
    endcase
  end

  // Outputs and commands.
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = CMD_NONE;
    unique case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o = CMD_LOAD;
      end
      ST_INIT:     cmd_o = CMD_INIT;
      ST_POP_CHK:  if (!status_i.sp_zero) cmd_o = CMD_POP;
      ST_POP_WAIT: cmd_o = CMD_RANGE_LD;
      ST_PIV_WAIT: cmd_o = CMD_PV_LD;
      ST_R_CHK:    if (!status_i.piv_eq_rgt) cmd_o = CMD_RD_RGT;
      ST_R_CMP:    cmd_o = CMD_R_STEP;
      ST_L_CHK:    if (!status_i.piv_eq_lft) cmd_o = CMD_RD_LFT;
      ST_L_CMP:    cmd_o = CMD_L_STEP;
      ST_FIN:      cmd_o = CMD_FIN;
      ST_PUSH_L:   cmd_o = CMD_PUSH_L;
      ST_PUSH_R:   cmd_o = CMD_PUSH_R;
      ST_OUT_RD:   cmd_o = CMD_OUT_RD;
      ST_OUT_LD:   cmd_o = CMD_OUT_LD;
      ST_OUT_HOLD: begin
        out_valid_o = 1'b1;
        if (out_ready_i) cmd_o = CMD_OUT_TAKE;
      end
      default: ;
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // Checks on the sequencing.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("loading while a beat is offered");
  a_last_to_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && status_i.out_last |=> in_ready_o)
    else $error("no return to loading after the final beat");
  a_sort_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && is_last_i |=> !in_ready_o)
    else $error("sort not started after the last item");

endmodule

`default_nettype wire

// File: design/quicksort_sorter_top.sv
// Top level of the quicksort sorter: controller and datapath.
// Loading accepts one item per cycle while in_ready_o is high; the last item starts the sort.
// The sort reads the store and compares in separate states for each element compare (one
// store read port); each output beat is read, loaded and then held until it is taken.
// New items are accepted only after the last sorted beat of a set has been taken.
// Reset is asynchronous and active low and empties the store and range stack.
`default_nettype none

module quicksort_sorter_top #(
  parameter int MAX_ELEMENTS = 64,
  parameter int DATA_WIDTH   = 32
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  wire signed [DATA_WIDTH-1:0]  value_i,
  input  wire                          is_last_i,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output logic signed [DATA_WIDTH-1:0] sorted_value_o,
  output logic                         last_out_o,
  output logic                         overflow_o
);
  import qs_pkg::*;

  cmd_e    cmd;
  status_t status;

  qs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .is_last_i   (is_last_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  qs_datapath #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .DATA_WIDTH   (DATA_WIDTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .value_i        (value_i),
    .status_o       (status),
    .sorted_value_o (sorted_value_o),
    .last_out_o     (last_out_o),
    .overflow_o     (overflow_o)
  );

endmodule

`default_nettype wire

// File: tb/sv/quicksort_sorter_top_test.sv
// Testbench for the quicksort sorter: random sets in, sorted runs checked out.
`default_nettype none

module quicksort_sorter_top_test;

  localparam int CAP = 64;
  localparam int DW  = 32;

  // Sorted run expectations: the predictor sorts each set and queues its beats.
  class sorted_run_board;
    logic signed [DW-1:0] set_vals[$];
    logic                 set_dropped;
    logic signed [DW-1:0] exp_val[$];
    logic                 exp_last[$];
    logic                 exp_ovf[$];
    int                   errors;

    function void note_input(logic signed [DW-1:0] v, logic last);
      logic signed [DW-1:0] tmp;
      int n;
      if (set_vals.size() < CAP) set_vals.push_back(v);
      else set_dropped = 1'b1;
      if (!last) return;
      n = set_vals.size();
      // Simple insertion sort; order of equal values does not matter in the output.
      for (int i = 1; i < n; i++) begin
        for (int j = i; j > 0 && set_vals[j] < set_vals[j-1]; j--) begin
          tmp = set_vals[j]; set_vals[j] = set_vals[j-1]; set_vals[j-1] = tmp;
        end
      end
      for (int k = 0; k < n; k++) begin
        exp_val.push_back(set_vals[k]);
        exp_last.push_back(k == n - 1);
        exp_ovf.push_back(set_dropped);
      end
      set_vals.delete();
      set_dropped = 1'b0;
    endfunction

    function void check_result(logic signed [DW-1:0] v, logic last, logic ovf);
      logic signed [DW-1:0] ev;
      logic el, eo;
      if (exp_val.size() == 0) begin
        $display("%0t: unexpected beat value=%0d last=%0b overflow=%0b", $time, v, last, ovf);
        errors++;
        return;
      end
      ev = exp_val.pop_front(); el = exp_last.pop_front(); eo = exp_ovf.pop_front();
      if (v !== ev) begin
        $display("%0t: sorted_value expected %0d actual %0d", $time, ev, v);
        errors++;
      end
      if (last !== el) begin
        $display("%0t: last_out expected %0b actual %0b", $time, el, last);
        errors++;
      end
      if (ovf !== eo) begin
        $display("%0t: overflow expected %0b actual %0b", $time, eo, ovf);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [DW-1:0] value_i = '0;
  logic is_last_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [DW-1:0] sorted_value_o;
  logic last_out_o;
  logic overflow_o;

  sorted_run_board board;
  bit hold_off = 1'b0;
  int next_gap = 0;

  quicksort_sorter_top #(.MAX_ELEMENTS(CAP), .DATA_WIDTH(DW)) DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .value_i(value_i), .is_last_i(is_last_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .sorted_value_o(sorted_value_o), .last_out_o(last_out_o), .overflow_o(overflow_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // Offer one beat and hold it until accepted; the idle gap after it is chosen at
  // acceptance so that valid drops only when no beat follows straight away.
  task automatic send_beat(logic signed [DW-1:0] v, logic last);
    repeat (next_gap) @(posedge clk_i);
    in_valid_i <= 1'b1;
    value_i    <= v;
    is_last_i  <= last;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_input(v, last);
    next_gap = gap_len();
    if (next_gap != 0) in_valid_i <= 1'b0;
  endtask

  // Drop valid when the sender pauses with no further beat lined up.
  task automatic release_valid();
    if (next_gap == 0) begin
      in_valid_i <= 1'b0;
      next_gap = 1;
    end
  endtask

  function automatic logic signed [DW-1:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed($urandom_range(0, 6)) - 3;
      default: return $signed($urandom());
    endcase
  endfunction

  task automatic send_set(int n);
    for (int i = 0; i < n; i++) send_beat(rand_value(), i == n - 1);
  endtask

  // Receiver: random stalls, with one long hold-off on request.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i)
        board.check_result(sorted_value_o, last_out_o, overflow_o);
      if (hold_off) out_ready_i <= 1'b0;
      else out_ready_i <= ($urandom_range(0, 9) < 7);
    end
  end

  initial begin
    #3000000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    int drain;
    board = new();
    board.set_dropped = 1'b0;
    board.errors = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: single element, extremes, duplicates, all bits both ways.
    send_beat(32'sh7fffffff, 1'b1);
    send_beat(32'sh80000000, 1'b0);
    send_beat(32'sh7fffffff, 1'b0);
    send_beat(32'sh00000000, 1'b0);
    send_beat(-32'sd1, 1'b0);
    send_beat(32'sh55555555, 1'b0);
    send_beat(32'shaaaaaaaa, 1'b0);
    send_beat(32'sd5, 1'b0);
    send_beat(32'sd5, 1'b1);
    for (int i = 0; i < 6; i++) send_beat(32'sd10 - i, i == 5);  // reversed order
    for (int i = 0; i < 4; i++) send_beat(i, i == 3);            // already sorted

    // Long receiver hold-off while a set is loaded and sorted.
    hold_off = 1'b1;
    fork
      begin repeat (600) @(posedge clk_i); hold_off = 1'b0; end
      begin send_set(12); send_set(3); release_valid(); end
    join

    // Overflow: 67 items into a 64-entry store, then a normal set after it.
    for (int i = 0; i < 67; i++) send_beat(rand_value(), i == 66);
    send_set(2);

    // A few short random sets.
    for (int t = 0; t < 3; t++) send_set($urandom_range(1, 4));
    release_valid();

    drain = 0;
    while (board.exp_val.size() != 0 && drain < 200000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (50) @(posedge clk_i);
    if (board.errors == 0 && board.exp_val.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
design/qs_pkg.sv
design/qs_datapath.sv
design/qs_ctrl.sv
design/quicksort_sorter_top.sv
tb/sv/quicksort_sorter_top_test.sv
